>>> rtl/spes_pkg.sv
// spes_pkg: shared constants, types and the schedule struct for the sorted pwm edge scheduler
// no dependencies; imported by spes_sort, the top level and the checker
package spes_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int LEVEL_W      = 8;
  localparam int LEVELS_W     = NUM_CHANNELS * LEVEL_W;
  localparam int GRP_W        = $clog2(NUM_CHANNELS + 1);
  localparam int IDX_W        = $clog2(NUM_CHANNELS + 1);
  localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
  localparam int TICKS_W      = 9;
  localparam int RELOAD_W     = 16;
  localparam int PROD_W       = LEVEL_W + TICKS_W;

  localparam logic [LEVEL_W-1:0]  FULL_SCALE_LEVEL = 8'hFF;
  localparam logic [RELOAD_W-1:0] RELOAD_TOP       = 16'hFFFF;
  localparam logic [TICKS_W-1:0]  TICKS_RESET      = 9'd16;
  localparam logic [TICKS_W-1:0]  TICKS_MAX        = 9'd256;

  typedef logic [LEVEL_W-1:0]      level_t;
  typedef logic [NUM_CHANNELS-1:0] chmask_t;
  typedef logic [GRP_W-1:0]        grp_t;

  // distinct nonzero levels ascending, mask 0 is switch-on, mask g+1 is level lvl[g]
  typedef struct packed {
    level_t [NUM_CHANNELS-1:0] lvl;
    chmask_t [NUM_CHANNELS:0]  mask;
    grp_t                      groups;
  } sched_t;

endpackage

>>> rtl/spes_sort.sv
// spes_sort: three-stage ranking pipeline, packed levels in, distinct-level schedule out
// depends on spes_pkg
module spes_sort (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [spes_pkg::LEVELS_W-1:0]  in_channel_levels,
  output logic                           sched_valid,
  input  logic                           sched_ready,
  output spes_pkg::sched_t               sched
);
  import spes_pkg::*;

  logic                      s1_valid_r, s2_valid_r, s3_valid_r;
  logic                      s1_ready, s2_ready, s3_ready;
  level_t [NUM_CHANNELS-1:0] s1_lev_r, s2_lev_r;
  level_t [NUM_CHANNELS-1:0] s1_lev_nxt;
  chmask_t                   s1_first_r, s1_first_nxt, s2_first_r;
  grp_t                      s2_rank_r [NUM_CHANNELS];
  grp_t                      s2_rank_nxt [NUM_CHANNELS];
  grp_t                      s2_groups_r;
  sched_t                    s3_sched_r, s3_sched_nxt;

  assign s3_ready = !s3_valid_r || sched_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // stage 1: unpack, flag the lowest-index channel of each nonzero level
  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      s1_lev_nxt[k] = in_channel_levels[k*LEVEL_W +: LEVEL_W];
    end
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      s1_first_nxt[k] = (s1_lev_nxt[k] != '0);
      for (int j = 0; j < k; j++) begin
        if (s1_lev_nxt[j] == s1_lev_nxt[k]) s1_first_nxt[k] = 1'b0;
      end
    end
  end

  // stage 2: group index of each channel = distinct levels below it
  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      s2_rank_nxt[k] = '0;
      for (int j = 0; j < NUM_CHANNELS; j++) begin
        if (s1_first_r[j] && (s1_lev_r[j] < s1_lev_r[k])) begin
          s2_rank_nxt[k] = s2_rank_nxt[k] + grp_t'(1);
        end
      end
    end
  end

  // stage 3: place distinct levels by rank, build the per-edge masks
  always_comb begin
    s3_sched_nxt        = '0;
    s3_sched_nxt.groups = s2_groups_r;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      s3_sched_nxt.mask[0][k] = (s2_lev_r[k] != '0);
    end
    for (int g = 0; g < NUM_CHANNELS; g++) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        if (s2_lev_r[k] != '0 && s2_rank_r[k] == grp_t'(g)) begin
          s3_sched_nxt.mask[g+1][k] = 1'b1;
        end
        if (s2_first_r[k] && s2_rank_r[k] == grp_t'(g)) begin
          s3_sched_nxt.lvl[g] = s3_sched_nxt.lvl[g] | s2_lev_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_lev_r   <= s1_lev_nxt;
      s1_first_r <= s1_first_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_lev_r    <= s1_lev_r;
      s2_first_r  <= s1_first_r;
      s2_rank_r   <= s2_rank_nxt;
      s2_groups_r <= grp_t'($countones(s1_first_r));
    end
    if (s3_ready && s2_valid_r) begin
      s3_sched_r <= s3_sched_nxt;
    end
  end

  assign sched_valid = s3_valid_r;
  assign sched       = s3_sched_r;

endmodule

>>> rtl/sorted_pwm_edge_scheduler_core.sv
// sorted_pwm_edge_scheduler_core: top level, ticks register, edge serializer, output register
// depends on spes_pkg and spes_sort
//
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | in_channel_levels[31:0]
//  out     | out_valid/out_ready | out_edge_index, out_timer_reload, out_channel_mask,
//          |                     | out_edge_groups, out_last_edge
//  cfg     | cfg_valid/cfg_ready | cfg_ticks_per_level[8:0]
//
// an item with G distinct nonzero levels gives G+1 results, one per cycle from the
// edge serializer while the output is not stalled, so an item gives 1 to 5 results
// the first result of an item reaches the out ports after the accepted item has passed
// three ranking stages, the serializer and the output register
// the ranking pipeline keeps accepting items while the serializer works
// cfg_ready is always high; ticks above 256 are stored as 256; reset value 16
// a stalled output holds every stage behind it without losing or repeating an item
module sorted_pwm_edge_scheduler_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [spes_pkg::LEVELS_W-1:0]    in_channel_levels,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spes_pkg::IDX_W-1:0]       out_edge_index,
  output logic [spes_pkg::RELOAD_W-1:0]    out_timer_reload,
  output logic [spes_pkg::NUM_CHANNELS-1:0] out_channel_mask,
  output logic [spes_pkg::GRP_W-1:0]       out_edge_groups,
  output logic                             out_last_edge,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spes_pkg::TICKS_W-1:0]     cfg_ticks_per_level
);
  import spes_pkg::*;

  logic [TICKS_W-1:0]   ticks_r;
  logic                 sched_valid, sched_ready;
  sched_t               sched;

  logic                 ser_valid_r;
  sched_t               ser_sched_r;
  logic [IDX_W-1:0]     ser_idx_r;
  logic                 out_free, emit, ser_last;
  level_t               cur_lev, prev_lev, diff;
  logic [PROD_W-1:0]    prod;

  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [RELOAD_W-1:0]  out_reload_r;
  chmask_t              out_mask_r;
  grp_t                 out_groups_r;
  logic                 out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ticks_r <= (cfg_ticks_per_level > TICKS_MAX) ? TICKS_MAX : cfg_ticks_per_level;
    end
  end

  spes_sort u_sort (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_channel_levels (in_channel_levels),
    .sched_valid       (sched_valid),
    .sched_ready       (sched_ready),
    .sched             (sched)
  );

  assign out_free    = !out_valid_r || out_ready;
  assign emit        = ser_valid_r && out_free;
  assign ser_last    = (ser_idx_r == IDX_W'(ser_sched_r.groups));
  assign sched_ready = !ser_valid_r || (emit && ser_last);

  // interval runs from the previous distinct level (or zero) to the next one (or full scale)
  always_comb begin
    cur_lev  = ser_last ? FULL_SCALE_LEVEL : ser_sched_r.lvl[ser_idx_r[CH_IDX_W-1:0]];
    prev_lev = '0;
    if (ser_idx_r != '0) begin
      prev_lev = ser_sched_r.lvl[CH_IDX_W'(ser_idx_r - IDX_W'(1))];
    end
    diff = cur_lev - prev_lev;
    prod = PROD_W'(diff) * PROD_W'(ticks_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (sched_ready) begin
        ser_valid_r <= sched_valid;
        ser_idx_r   <= '0;
      end else if (emit) begin
        ser_idx_r <= ser_idx_r + IDX_W'(1);
      end
      if (out_free) out_valid_r <= ser_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sched_ready && sched_valid) ser_sched_r <= sched;
    if (emit) begin
      out_idx_r    <= ser_idx_r;
      out_reload_r <= RELOAD_TOP - prod[RELOAD_W-1:0];
      out_mask_r   <= ser_sched_r.mask[ser_idx_r];
      out_groups_r <= ser_sched_r.groups;
      out_last_r   <= ser_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_edge_index   = out_idx_r;
  assign out_timer_reload = out_reload_r;
  assign out_channel_mask = out_mask_r;
  assign out_edge_groups  = out_groups_r;
  assign out_last_edge    = out_last_r;

endmodule

>>> rtl/spes_checker.sv
// spes_checker: port-level assertions on the result run of the edge scheduler
// depends on spes_pkg; bound to sorted_pwm_edge_scheduler_core below
module spes_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [spes_pkg::IDX_W-1:0]        out_edge_index,
  input logic [spes_pkg::RELOAD_W-1:0]     out_timer_reload,
  input logic [spes_pkg::NUM_CHANNELS-1:0] out_channel_mask,
  input logic [spes_pkg::GRP_W-1:0]        out_edge_groups,
  input logic                              out_last_edge
);
  import spes_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_timer_reload)
      && $stable(out_edge_index))
    else $error("stalled result changed");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_edge_index <= out_edge_groups)
    else $error("edge index beyond group count");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_edge |-> out_edge_index == out_edge_groups)
    else $error("last edge at wrong position");

  // distinct levels never exceed the number of lit channels
  a_on_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_index == '0 |-> $countones(out_channel_mask) >= out_edge_groups)
    else $error("switch-on mask smaller than group count");

  a_off_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_index != '0 |-> out_channel_mask != '0)
    else $error("empty switch-off mask");

endmodule

bind sorted_pwm_edge_scheduler_core spes_checker u_spes_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_edge_index   (out_edge_index),
  .out_timer_reload (out_timer_reload),
  .out_channel_mask (out_channel_mask),
  .out_edge_groups  (out_edge_groups),
  .out_last_edge    (out_last_edge)
);
